FILE: rtl/mccps_pkg.sv
// Shared types, constants and tables for the MIDI CC profile selector.
package mccps_pkg;

    localparam int MAX_PROFILES = 32;
    localparam int IDX_W        = $clog2(MAX_PROFILES);
    localparam int PROF_W       = IDX_W + 1;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CC_STATUS_BASE = 8'hB0;
    localparam logic [6:0] CC_VALUE_MAX   = 7'd127;

    localparam logic [4:0] RST_CHANNEL    = 5'd1;
    localparam logic [6:0] RST_CONTROLLER = 7'd119;
    localparam logic [5:0] RST_COUNT      = 6'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL    = 2'd0;
    localparam logic [1:0] CFG_CONTROLLER = 2'd1;
    localparam logic [1:0] CFG_COUNT      = 2'd2;

    // result kinds
    localparam logic OUT_SEND_CC = 1'b0;
    localparam logic OUT_CHANGE  = 1'b1;

    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_SET    = 1'b1
    } t_op_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic       command;
        logic [7:0] in_status;
        logic [7:0] in_data1;
        logic [7:0] in_data2;
        logic [5:0] set_profile;
    } t_in;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_status;
        logic [6:0] out_controller;
        logic [6:0] out_value;
        logic [5:0] out_profile;
    } t_out;

    // queued operation between front and back
    typedef struct packed {
        t_op_kind          kind;
        logic [6:0]        value;
        logic [PROF_W-1:0] profile;
    } t_op;

    // settled configuration, already clamped
    typedef struct packed {
        logic [7:0]        status;
        logic [6:0]        controller;
        logic [PROF_W-1:0] count;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       quo;
        logic [IDX_W-1:0] rem;
    } t_recip;

    // 128 / d and 128 % d for the profile spacing d = count - 1
    function automatic t_recip recip_128(input logic [IDX_W-1:0] d);
        t_recip res;
        case (d)
            5'd1:    res = '{8'd128, 5'd0};
            5'd2:    res = '{8'd64,  5'd0};
            5'd3:    res = '{8'd42,  5'd2};
            5'd4:    res = '{8'd32,  5'd0};
            5'd5:    res = '{8'd25,  5'd3};
            5'd6:    res = '{8'd21,  5'd2};
            5'd7:    res = '{8'd18,  5'd2};
            5'd8:    res = '{8'd16,  5'd0};
            5'd9:    res = '{8'd14,  5'd2};
            5'd10:   res = '{8'd12,  5'd8};
            5'd11:   res = '{8'd11,  5'd7};
            5'd12:   res = '{8'd10,  5'd8};
            5'd13:   res = '{8'd9,   5'd11};
            5'd14:   res = '{8'd9,   5'd2};
            5'd15:   res = '{8'd8,   5'd8};
            5'd16:   res = '{8'd8,   5'd0};
            5'd17:   res = '{8'd7,   5'd9};
            5'd18:   res = '{8'd7,   5'd2};
            5'd19:   res = '{8'd6,   5'd14};
            5'd20:   res = '{8'd6,   5'd8};
            5'd21:   res = '{8'd6,   5'd2};
            5'd22:   res = '{8'd5,   5'd18};
            5'd23:   res = '{8'd5,   5'd13};
            5'd24:   res = '{8'd5,   5'd8};
            5'd25:   res = '{8'd5,   5'd3};
            5'd26:   res = '{8'd4,   5'd24};
            5'd27:   res = '{8'd4,   5'd20};
            5'd28:   res = '{8'd4,   5'd16};
            5'd29:   res = '{8'd4,   5'd12};
            5'd30:   res = '{8'd4,   5'd8};
            5'd31:   res = '{8'd4,   5'd4};
            default: res = '{8'd0,   5'd0};
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/mccps_front.sv
// Front end: filters received messages and turns transactions into queued operations.
module mccps_front import mccps_pkg::*; (
    input  t_cfg i_cfg,
    input  t_in  i_item,
    output logic o_keep,
    output t_op  o_op
);

    logic match;

    assign match = (i_item.in_status == i_cfg.status)
                && (i_item.in_data1 == {1'b0, i_cfg.controller})
                && !i_item.in_data2[7];

    always_comb begin
        o_keep        = i_item.command ? 1'b1 : match;
        o_op.kind     = i_item.command ? OP_SET : OP_DECODE;
        o_op.value    = i_item.in_data2[6:0];
        // clamp the local set to 1..count
        if (i_item.set_profile == '0) begin
            o_op.profile = PROF_W'(1);
        end else if (i_item.set_profile > i_cfg.count) begin
            o_op.profile = i_cfg.count;
        end else begin
            o_op.profile = i_item.set_profile;
        end
    end

endmodule

FILE: rtl/mccps_fifo.sv
// Short operation queue between the front and back ends.
module mccps_fifo import mccps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_data
);

    t_op                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/mccps_back.sv
// Back end: profile search and encoding sequencer, profile state and result register.
module mccps_back import mccps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_op_valid,
    input  t_op  i_op,
    output logic o_op_pop,
    output logic o_out_valid,
    output t_out o_out,
    input  logic i_out_stall
);

    t_back_state       r_state, n_state;
    t_op               r_op, n_op;
    logic [IDX_W-1:0]  r_d, n_d;
    logic [7:0]        r_a, n_a;
    logic [IDX_W-1:0]  r_b, n_b;
    logic [7:0]        r_q, n_q;
    logic [IDX_W-1:0]  r_r, n_r;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_best, n_best;
    logic [6:0]        r_best_dist, n_best_dist;
    logic [6:0]        r_enc, n_enc;
    logic [PROF_W-1:0] r_prof, n_prof;
    logic [PROF_W-1:0] r_current, n_current;
    logic [PROF_W-1:0] r_echo, n_echo;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    t_recip            rcp;
    logic [IDX_W-1:0]  d_now;
    logic [6:0]        enc_i;
    logic [6:0]        gap;
    logic              better;
    logic [IDX_W:0]    sum_r;
    logic              wrap;
    logic [IDX_W-1:0]  win_idx;
    logic [PROF_W-1:0] win_prof;
    logic              single;

    assign single      = (i_cfg.count == PROF_W'(1));
    assign d_now       = IDX_W'(i_cfg.count - PROF_W'(1));
    assign rcp         = recip_128(d_now);
    assign enc_i       = (r_q > {1'b0, CC_VALUE_MAX}) ? CC_VALUE_MAX : r_q[6:0];
    assign gap         = (enc_i >= r_op.value) ? enc_i - r_op.value : r_op.value - enc_i;
    assign better      = (r_i == '0) || (gap < r_best_dist);
    assign sum_r       = {1'b0, r_r} + {1'b0, r_b};
    assign wrap        = (sum_r >= {1'b0, r_d});
    assign win_idx     = better ? r_i : r_best;
    assign win_prof    = {1'b0, win_idx} + PROF_W'(1);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_d         = r_d;
        n_a         = r_a;
        n_b         = r_b;
        n_q         = r_q;
        n_r         = r_r;
        n_i         = r_i;
        n_best      = r_best;
        n_best_dist = r_best_dist;
        n_enc       = r_enc;
        n_prof      = r_prof;
        n_current   = r_current;
        n_echo      = r_echo;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_op_pop    = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (i_op_valid) begin
                    o_op_pop = 1'b1;
                    n_op     = i_op;
                    n_d      = d_now;
                    n_a      = rcp.quo;
                    n_b      = rcp.rem;
                    n_q      = '0;
                    n_r      = d_now >> 1;
                    n_i      = '0;
                    n_enc    = '0;
                    if (i_op.kind == OP_SET) begin
                        n_current = i_op.profile;
                        n_prof    = i_op.profile;
                        if (i_op.profile == r_echo) begin
                            // echo of our own change: swallow it
                            n_echo = '0;
                        end else if (single) begin
                            n_state = BK_EMIT;
                        end else begin
                            n_state = BK_WALK;
                        end
                    end else if (single) begin
                        if (r_current != PROF_W'(1)) begin
                            n_current = PROF_W'(1);
                            n_echo    = PROF_W'(1);
                            n_prof    = PROF_W'(1);
                            n_state   = BK_EMIT;
                        end
                    end else begin
                        n_state = BK_WALK;
                    end
                end
            end
            BK_WALK: begin
                if (better) begin
                    n_best      = r_i;
                    n_best_dist = gap;
                end
                // step to the next profile: q,r track (128*i + d/2) / d
                n_i = r_i + 1'b1;
                n_r = wrap ? IDX_W'(sum_r - {1'b0, r_d}) : sum_r[IDX_W-1:0];
                n_q = r_q + r_a + {7'd0, wrap};
                if (r_op.kind == OP_SET) begin
                    if (r_i == IDX_W'(r_op.profile - PROF_W'(1))) begin
                        n_enc   = enc_i;
                        n_state = BK_EMIT;
                    end
                end else if (r_i == r_d) begin
                    if (win_prof == r_current) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_current = win_prof;
                        n_echo    = win_prof;
                        n_prof    = win_prof;
                        n_state   = BK_EMIT;
                    end
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid        = 1'b1;
                    n_out.out_kind     = (r_op.kind == OP_SET) ? OUT_SEND_CC : OUT_CHANGE;
                    n_out.out_status   = i_cfg.status;
                    n_out.out_controller = i_cfg.controller;
                    n_out.out_value    = (r_op.kind == OP_SET) ? r_enc : 7'd0;
                    n_out.out_profile  = r_prof;
                    n_state            = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_current   <= PROF_W'(1);
            r_echo      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_current   <= n_current;
            r_echo      <= n_echo;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_d         <= n_d;
        r_a         <= n_a;
        r_b         <= n_b;
        r_q         <= n_q;
        r_r         <= n_r;
        r_i         <= n_i;
        r_best      <= n_best;
        r_best_dist <= n_best_dist;
        r_enc       <= n_enc;
        r_prof      <= n_prof;
        r_out       <= n_out;
    end

endmodule

FILE: rtl/midi_cc_profile_selector_top.sv
// MIDI CC profile selector: transaction ports, configuration registers, front, queue, back.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): either a received MIDI
// message (command 0) or a local profile set (command 1). A message on another
// status, controller, or with data2 above 127 is dropped at the front end.
// Output channel (o_out_valid / i_out_stall, payload o_out): at most one result
// per input transaction, a CC message to send or a profile-change request.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 channel, 1 controller, 2 profile count); other indexes are ignored.
// Write it only while the block is idle.
// Flow: an accepted transaction enters a two-entry queue; the back end then
// walks the profiles one per cycle when count is above 1, over the whole table
// for a received message and up to profile p for a local set of profile p. It
// takes the next queued item only once it has finished with the last one.
// Reset (synchronous, active low): registers return to channel 1, controller
// 119, two profiles, current profile 1, no echo armed, queue and output empty.
// A stalled result holds in the output register; the queue keeps accepting
// until it is full, then o_in_stall rises.
module midi_cc_profile_selector_top import mccps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    logic [4:0]        r_channel;
    logic [6:0]        r_controller;
    logic [5:0]        r_count;
    t_cfg              cfg;
    logic [3:0]        chan_m1;
    logic              keep;
    t_op               front_op;
    logic              fifo_full;
    logic              fifo_valid;
    t_op               fifo_op;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel    <= RST_CHANNEL;
            r_controller <= RST_CONTROLLER;
            r_count      <= RST_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNEL:    r_channel    <= i_cfg_data[4:0];
                CFG_CONTROLLER: r_controller <= i_cfg_data;
                CFG_COUNT:      r_count      <= i_cfg_data[5:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        if (r_channel == 5'd0) begin
            chan_m1 = 4'd0;
        end else if (r_channel > 5'd16) begin
            chan_m1 = 4'd15;
        end else begin
            chan_m1 = 4'(r_channel - 5'd1);
        end
        cfg.status     = CC_STATUS_BASE | {4'd0, chan_m1};
        cfg.controller = r_controller;
        if (r_count == '0) begin
            cfg.count = PROF_W'(1);
        end else if (r_count > PROF_W'(MAX_PROFILES)) begin
            cfg.count = PROF_W'(MAX_PROFILES);
        end else begin
            cfg.count = r_count;
        end
    end

    assign o_in_stall = fifo_full;

    mccps_front u_front (
        .i_cfg  (cfg),
        .i_item (i_in),
        .o_keep (keep),
        .o_op   (front_op)
    );

    mccps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !fifo_full && keep),
        .i_data  (front_op),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_data  (fifo_op)
    );

    mccps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_op_valid  (fifo_valid),
        .i_op        (fifo_op),
        .o_op_pop    (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
